// ===== hw/rtl/sequence_reorder_window_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sequence reorder window
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_REORDER_WINDOW_ASSERT_SVH
`define SEQUENCE_REORDER_WINDOW_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SRW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reorder window check failed");

// Next-cycle implication, disabled during reset
`define SRW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reorder window check failed");

`endif

// ===== hw/rtl/srw_pkg.sv =====
// ----------------------------------------------------------------------------
// srw_pkg
// Types, codes and sizes shared by the sequence reorder window and its checker.
// ----------------------------------------------------------------------------
package srw_pkg;

  // Window geometry (slot count must be a power of two)
  localparam int WINDOW_SLOTS = 64;
  localparam int COMMAND_BITS = 64;
  localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
  // Slots examined per cycle by the gap scanner
  localparam int SCAN_LANES   = 8;

  // Field widths
  localparam int SEQ_W   = 32;
  localparam int SKIP_W  = 6;
  localparam int DATA_W  = 64;

  // Item commands
  localparam logic [2:0] CMD_HEADER = 3'd0;
  localparam logic [2:0] CMD_RECORD = 3'd1;
  localparam logic [2:0] CMD_POP    = 3'd2;
  localparam logic [2:0] CMD_SKIP   = 3'd3;
  localparam logic [2:0] CMD_RESET  = 3'd4;

  // Result status codes
  localparam logic [3:0] STAT_STORED    = 4'd0;
  localparam logic [3:0] STAT_DUP       = 4'd1;
  localparam logic [3:0] STAT_AHEAD     = 4'd2;
  localparam logic [3:0] STAT_DELIVERED = 4'd3;
  localparam logic [3:0] STAT_NOT_READY = 4'd4;
  localparam logic [3:0] STAT_SKIPPED   = 4'd5;
  localparam logic [3:0] STAT_NO_SKIP   = 4'd6;
  localparam logic [3:0] STAT_RELOCKED  = 4'd7;
  localparam logic [3:0] STAT_SAME      = 4'd8;
  localparam logic [3:0] STAT_RESET     = 4'd9;
  localparam logic [3:0] STAT_IGNORED   = 4'd10;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  // Input item
  typedef struct packed {
    logic [2:0]        cmd;
    logic [SEQ_W-1:0]  stream_ident;
    logic [SEQ_W-1:0]  first_seq;
    logic              keyframe;
    logic [15:0]       rec_index;
    logic [DATA_W-1:0] command_data;
  } req_t;

  // Result item
  typedef struct packed {
    logic [3:0]        status;
    logic [DATA_W-1:0] out_command;
    logic [SEQ_W-1:0]  out_seq;
    logic [SKIP_W-1:0] skip_amount;
    logic              stalled_gap;
    logic [SEQ_W-1:0]  stored_total;
    logic [SEQ_W-1:0]  dup_total;
    logic [SEQ_W-1:0]  ahead_total;
    logic [SEQ_W-1:0]  gaps_total;
  } rsp_t;

endpackage

// ===== hw/rtl/sequence_reorder_window.sv =====
// ----------------------------------------------------------------------------
// sequence_reorder_window
// Reorder window of 64 slots indexed by sequence number modulo the slot count.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one command item: packet
//   header, record insert, pop head, skip gap or window reset. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one result item per command.
//   The item is registered on acceptance and its result is registered from the
//   EXEC state, so a new item is not accepted until the block is idle again.
//   A skip over a gap runs the 8-slot scanner from the slot after the head,
//   one group per cycle until it finds a stored command.
//   The command store is a single-port memory; a pop reads the head entry in
//   the accept cycle and delivers it from the EXEC state.
//   The result sits in an output register: a new item can be accepted while
//   it waits. If rsp_ready stays low, the next item holds before committing
//   and req_ready stays low until the pending result is taken.
//   Reset (rst, synchronous) clears all present marks, the lock, the delivery
//   point, the latched base and all counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sequence_reorder_window (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  srw_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output srw_pkg::rsp_t rsp
);

  // Sequencer
  srw_pkg::state_t state, state_next;

  // Latched item and its record sequence
  srw_pkg::req_t          item;
  logic [31:0]            rec_seq;

  // Window state
  logic [srw_pkg::WINDOW_SLOTS-1:0] present, present_next;
  logic [31:0] deliver_point, deliver_point_next;
  logic [31:0] locked_stream, locked_stream_next;
  logic        locked, locked_next;
  logic [31:0] packet_base, packet_base_next;
  logic [31:0] stored_count, stored_count_next;
  logic [31:0] dup_count, dup_count_next;
  logic [31:0] ahead_count, ahead_count_next;
  logic [31:0] gap_count, gap_count_next;

  // Gap scanner
  logic [srw_pkg::SLOT_W-1:0] scan_off, scan_off_next;
  logic                       scan_hit;
  logic [srw_pkg::SLOT_W-1:0] scan_dist;

  // Command store
  logic [srw_pkg::COMMAND_BITS-1:0] cmd_mem [srw_pkg::WINDOW_SLOTS];
  logic [srw_pkg::COMMAND_BITS-1:0] rd_data;
  logic                             mem_we;
  logic [srw_pkg::SLOT_W-1:0]       mem_addr;

  // Output register
  logic          rsp_valid_next;
  srw_pkg::rsp_t rsp_next;

  logic                       accept;
  logic                       out_free;
  logic [srw_pkg::SLOT_W-1:0] head;
  logic [31:0]                rec_dist;
  logic [srw_pkg::SLOT_W-1:0] rec_slot;
  logic [31:0]                scan_dist_ext;

  assign req_ready     = (state == srw_pkg::ST_IDLE);
  assign accept        = req_valid && req_ready;
  assign out_free      = !rsp_valid || rsp_ready;
  assign head          = deliver_point[srw_pkg::SLOT_W-1:0];
  assign rec_dist      = rec_seq - deliver_point;
  assign rec_slot      = rec_seq[srw_pkg::SLOT_W-1:0];
  assign scan_dist_ext = 32'(scan_dist);

  // Scanner: first present slot among the current group of offsets
  always_comb begin
    logic [srw_pkg::SLOT_W-1:0] lane_off;
    logic [srw_pkg::SLOT_W-1:0] lane_slot;
    scan_hit  = 1'b0;
    scan_dist = '0;
    for (int j = 0; j < srw_pkg::SCAN_LANES; j++) begin
      lane_off  = scan_off + srw_pkg::SLOT_W'(j);
      lane_slot = head + lane_off;
      if (!scan_hit && present[lane_slot]) begin
        scan_hit  = 1'b1;
        scan_dist = lane_off;
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, window update and result
  always_comb begin
    logic          commit;
    srw_pkg::rsp_t res;
    state_next         = state;
    present_next       = present;
    deliver_point_next = deliver_point;
    locked_stream_next = locked_stream;
    locked_next        = locked;
    packet_base_next   = packet_base;
    stored_count_next  = stored_count;
    dup_count_next     = dup_count;
    ahead_count_next   = ahead_count;
    gap_count_next     = gap_count;
    scan_off_next      = scan_off;
    mem_we             = 1'b0;
    mem_addr           = rec_slot;
    commit             = 1'b0;
    res                = '0;
    res.status         = srw_pkg::STAT_IGNORED;

    case (state)
      srw_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = srw_pkg::ST_EXEC;
        end
      end

      srw_pkg::ST_EXEC: begin
        if (item.cmd == srw_pkg::CMD_SKIP && locked && !present[head] && (|present)) begin
          // a later slot holds a command: go find it
          state_next    = srw_pkg::ST_SCAN;
          scan_off_next = srw_pkg::SLOT_W'(1);
        end else if (out_free) begin
          commit = 1'b1;
          case (item.cmd)
            srw_pkg::CMD_HEADER: begin
              if (!locked || item.stream_ident != locked_stream || item.keyframe) begin
                present_next       = '0;
                locked_next        = 1'b1;
                locked_stream_next = item.stream_ident;
                deliver_point_next = item.first_seq;
                res.status         = srw_pkg::STAT_RELOCKED;
              end else begin
                res.status = srw_pkg::STAT_SAME;
              end
              packet_base_next = item.first_seq;
            end
            srw_pkg::CMD_RESET: begin
              present_next = '0;
              locked_next  = 1'b0;
              res.status   = srw_pkg::STAT_RESET;
            end
            srw_pkg::CMD_RECORD: begin
              if (locked) begin
                if (rec_dist[31]) begin
                  dup_count_next = dup_count + 32'd1;
                  res.status     = srw_pkg::STAT_DUP;
                end else if (rec_dist >= 32'(srw_pkg::WINDOW_SLOTS)) begin
                  ahead_count_next = ahead_count + 32'd1;
                  res.status       = srw_pkg::STAT_AHEAD;
                end else if (present[rec_slot]) begin
                  dup_count_next = dup_count + 32'd1;
                  res.status     = srw_pkg::STAT_DUP;
                end else begin
                  mem_we                 = 1'b1;
                  present_next[rec_slot] = 1'b1;
                  stored_count_next      = stored_count + 32'd1;
                  res.status             = srw_pkg::STAT_STORED;
                end
              end
            end
            srw_pkg::CMD_POP: begin
              if (locked) begin
                if (present[head]) begin
                  res.out_command    = 64'(rd_data);
                  res.out_seq        = deliver_point;
                  present_next[head] = 1'b0;
                  deliver_point_next = deliver_point + 32'd1;
                  res.status         = srw_pkg::STAT_DELIVERED;
                end else begin
                  res.status = srw_pkg::STAT_NOT_READY;
                end
              end
            end
            srw_pkg::CMD_SKIP: begin
              // head ready or nothing buffered
              if (locked) begin
                res.status = srw_pkg::STAT_NO_SKIP;
              end
            end
            default: begin
              res.status = srw_pkg::STAT_IGNORED;
            end
          endcase
          state_next = srw_pkg::ST_IDLE;
        end
      end

      srw_pkg::ST_SCAN: begin
        if (scan_hit) begin
          if (out_free) begin
            commit             = 1'b1;
            deliver_point_next = deliver_point + scan_dist_ext;
            gap_count_next     = gap_count + 32'd1;
            res.skip_amount    = scan_dist_ext[srw_pkg::SKIP_W-1:0];
            res.status         = srw_pkg::STAT_SKIPPED;
            state_next         = srw_pkg::ST_IDLE;
          end
        end else begin
          scan_off_next = scan_off + srw_pkg::SLOT_W'(srw_pkg::SCAN_LANES);
        end
      end

      default: begin
        state_next = srw_pkg::ST_IDLE;
      end
    endcase

    // Result fields that reflect the window after the step
    res.stalled_gap  = locked_next
                       && !present_next[deliver_point_next[srw_pkg::SLOT_W-1:0]]
                       && (|present_next);
    res.stored_total = stored_count_next;
    res.dup_total    = dup_count_next;
    res.ahead_total  = ahead_count_next;
    res.gaps_total   = gap_count_next;

    // Output register load and drain
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid;
    if (commit) begin
      rsp_next       = res;
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  // Control and window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      present       <= '0;
      deliver_point <= '0;
      locked_stream <= '0;
      locked        <= 1'b0;
      packet_base   <= '0;
      stored_count  <= '0;
      dup_count     <= '0;
      ahead_count   <= '0;
      gap_count     <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      present       <= present_next;
      deliver_point <= deliver_point_next;
      locked_stream <= locked_stream_next;
      locked        <= locked_next;
      packet_base   <= packet_base_next;
      stored_count  <= stored_count_next;
      dup_count     <= dup_count_next;
      ahead_count   <= ahead_count_next;
      gap_count     <= gap_count_next;
      rsp_valid     <= rsp_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item    <= req;
      rec_seq <= packet_base + 32'(req.rec_index);
    end
    scan_off <= scan_off_next;
    rsp      <= rsp_next;
  end

  // Command store: write on insert, head read in the accept cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cmd_mem[mem_addr] <= item.command_data[srw_pkg::COMMAND_BITS-1:0];
    end
    if (accept) begin
      rd_data <= cmd_mem[head];
    end
  end

endmodule

// ===== hw/rtl/srw_checker.sv =====
// ----------------------------------------------------------------------------
// srw_checker
// Port-level checks for the sequence reorder window, bound to the top level.
// ----------------------------------------------------------------------------
`include "sequence_reorder_window_assert.svh"

module srw_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input srw_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input srw_pkg::rsp_t rsp
);

  // a stalled result holds
  `SRW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

  // the block is busy in the cycle after taking an item
  `SRW_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

  // command and sequence are only shown on a delivery
  `SRW_ASSERT_NOW(a_deliver_fields, rsp_valid && rsp.status != srw_pkg::STAT_DELIVERED, rsp.out_command == '0 && rsp.out_seq == '0)

  // skip distance is only shown on a skip
  `SRW_ASSERT_NOW(a_skip_field, rsp_valid && rsp.status != srw_pkg::STAT_SKIPPED, rsp.skip_amount == '0)

endmodule

bind sequence_reorder_window srw_checker u_srw_checker (.*);

// ===== tb/sv/sequence_reorder_window_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_reorder_window_tb
// Drives header, record, pop, skip and reset items into the reorder window.
// A behavioral copy of the window predicts one result per accepted item, and
// every returned result is compared field by field in arrival order. A short
// directed run covers the corner cases. A long random run follows: mostly
// shuffled packets with gaps and repeats, plus noise items. Both sides idle at
// random, the receiver holds off once long enough to back up the input, and
// the sender drains the block to empty at a few points.
// ----------------------------------------------------------------------------
module sequence_reorder_window_tb;

  localparam int          RANDOM_ITEMS = 1200;
  localparam int          IDLE_PCT     = 7;
  localparam int          HOLD_AT      = 300;
  localparam int          HOLD_CYCLES  = 200;
  localparam logic [2:0]  CMD_LAST     = 3'd7;

  typedef struct {
    srw_pkg::req_t item;
    bit            drain_first;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  srw_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  srw_pkg::rsp_t rsp;

  stim_t         stim_q[$];
  srw_pkg::rsp_t results_due[$];
  int    total_items = 0;
  int    accepted_total = 0;
  int    outstanding = 0;
  int    fail_count = 0;
  int    hold_left = 0;
  bit    hold_done = 1'b0;
  logic  quiet;

  // Window model state
  bit [srw_pkg::WINDOW_SLOTS-1:0] mark = '0;
  bit [srw_pkg::DATA_W-1:0]       entry [srw_pkg::WINDOW_SLOTS];
  logic [srw_pkg::SEQ_W-1:0]      head_seq = '0;
  logic [srw_pkg::SEQ_W-1:0]      lock_sid = '0;
  bit                             is_locked = 1'b0;
  logic [srw_pkg::SEQ_W-1:0]      pkt_base = '0;
  logic [srw_pkg::SEQ_W-1:0]      n_stored = '0;
  logic [srw_pkg::SEQ_W-1:0]      n_dup = '0;
  logic [srw_pkg::SEQ_W-1:0]      n_ahead = '0;
  logic [srw_pkg::SEQ_W-1:0]      n_gaps = '0;

  sequence_reorder_window uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // No idling on either side over this stretch of items
  assign quiet = accepted_total >= 600 && accepted_total < 800;

  function automatic int slot_of(input logic [srw_pkg::SEQ_W-1:0] seq);
    return int'(seq % 32'(srw_pkg::WINDOW_SLOTS));
  endfunction

  // Distance from the head to the first marked slot past it, 0 if none
  function automatic int gap_to_next();
    for (int i = 1; i < srw_pkg::WINDOW_SLOTS; i++)
      if (mark[slot_of(head_seq + 32'(i))]) return i;
    return 0;
  endfunction

  // Apply one item to the window model and return its result
  function automatic srw_pkg::rsp_t window_step(input srw_pkg::req_t r);
    srw_pkg::rsp_t             o;
    int                        head;
    int                        gap;
    logic [srw_pkg::SEQ_W-1:0] seq;
    logic [srw_pkg::SEQ_W-1:0] span;
    o = '0;
    o.status = srw_pkg::STAT_IGNORED;
    head = slot_of(head_seq);
    if (r.cmd == srw_pkg::CMD_HEADER) begin
      if (!is_locked || r.stream_ident != lock_sid || r.keyframe) begin
        mark = '0;
        is_locked = 1'b1;
        lock_sid = r.stream_ident;
        head_seq = r.first_seq;
        o.status = srw_pkg::STAT_RELOCKED;
      end else begin
        o.status = srw_pkg::STAT_SAME;
      end
      pkt_base = r.first_seq;
    end else if (r.cmd == srw_pkg::CMD_RESET) begin
      mark = '0;
      is_locked = 1'b0;
      o.status = srw_pkg::STAT_RESET;
    end else if (r.cmd == srw_pkg::CMD_RECORD && is_locked) begin
      seq = pkt_base + 32'(r.rec_index);
      span = seq - head_seq;
      if (span[srw_pkg::SEQ_W-1]) begin
        n_dup++;
        o.status = srw_pkg::STAT_DUP;
      end else if (span >= 32'(srw_pkg::WINDOW_SLOTS)) begin
        n_ahead++;
        o.status = srw_pkg::STAT_AHEAD;
      end else if (mark[slot_of(seq)]) begin
        n_dup++;
        o.status = srw_pkg::STAT_DUP;
      end else begin
        entry[slot_of(seq)] = r.command_data;
        mark[slot_of(seq)] = 1'b1;
        n_stored++;
        o.status = srw_pkg::STAT_STORED;
      end
    end else if (r.cmd == srw_pkg::CMD_POP && is_locked) begin
      if (mark[head]) begin
        o.out_command = entry[head];
        o.out_seq = head_seq;
        mark[head] = 1'b0;
        head_seq++;
        o.status = srw_pkg::STAT_DELIVERED;
      end else begin
        o.status = srw_pkg::STAT_NOT_READY;
      end
    end else if (r.cmd == srw_pkg::CMD_SKIP && is_locked) begin
      gap = mark[head] ? 0 : gap_to_next();
      if (gap != 0) begin
        head_seq += 32'(gap);
        n_gaps++;
        o.skip_amount = srw_pkg::SKIP_W'(gap);
        o.status = srw_pkg::STAT_SKIPPED;
      end else begin
        o.status = srw_pkg::STAT_NO_SKIP;
      end
    end
    o.stalled_gap = is_locked && !mark[slot_of(head_seq)] && gap_to_next() != 0;
    o.stored_total = n_stored;
    o.dup_total = n_dup;
    o.ahead_total = n_ahead;
    o.gaps_total = n_gaps;
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic srw_pkg::req_t rand_item(input logic [2:0] c);
    srw_pkg::req_t r;
    r.cmd = c;
    r.stream_ident = $urandom;
    r.first_seq = $urandom;
    r.keyframe = 1'($urandom_range(1));
    r.rec_index = 16'($urandom_range(16'hFFFF));
    r.command_data = {$urandom, $urandom};
    return r;
  endfunction

  function automatic srw_pkg::req_t header_item(input logic [srw_pkg::SEQ_W-1:0] sid,
                                                input logic [srw_pkg::SEQ_W-1:0] base,
                                                input bit key);
    srw_pkg::req_t r;
    r = rand_item(srw_pkg::CMD_HEADER);
    r.stream_ident = sid;
    r.first_seq = base;
    r.keyframe = key;
    return r;
  endfunction

  function automatic srw_pkg::req_t record_item(input logic [15:0] idx);
    srw_pkg::req_t r;
    r = rand_item(srw_pkg::CMD_RECORD);
    r.rec_index = idx;
    return r;
  endfunction

  function automatic void queue_item(input srw_pkg::req_t r);
    stim_t s;
    s.item = r;
    s.drain_first = 1'b0;
    stim_q.push_back(s);
  endfunction

  // Sender: presents the next pending item, idles at random, drains on request
  always @(posedge clk) begin
    bit load;
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
    end else if (!req_valid || req_ready) begin
      load = stim_q.size() != 0;
      if (load && stim_q[0].drain_first && (req_valid || outstanding != 0)) load = 1'b0;
      if (load && !quiet && $urandom_range(99) < IDLE_PCT) load = 1'b0;
      if (load) begin
        req <= stim_q[0].item;
        stim_q.pop_front();
      end
      req_valid <= load;
    end
  end

  // Receiver: random stalls plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (!hold_done && accepted_total >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= quiet || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // Monitor: check results against predictions, then predict accepted items
  always @(posedge clk) begin
    srw_pkg::rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, rsp);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("status", 64'(want.status), 64'(rsp.status));
          check_field("out_command", want.out_command, rsp.out_command);
          check_field("out_seq", 64'(want.out_seq), 64'(rsp.out_seq));
          check_field("skip_amount", 64'(want.skip_amount), 64'(rsp.skip_amount));
          check_field("stalled_gap", 64'(want.stalled_gap), 64'(rsp.stalled_gap));
          check_field("stored_total", 64'(want.stored_total), 64'(rsp.stored_total));
          check_field("dup_total", 64'(want.dup_total), 64'(rsp.dup_total));
          check_field("ahead_total", 64'(want.ahead_total), 64'(rsp.ahead_total));
          check_field("gaps_total", 64'(want.gaps_total), 64'(rsp.gaps_total));
        end
      end
      if (req_valid && req_ready) results_due.push_back(window_step(req));
      accepted_total <= accepted_total + int'(req_valid && req_ready);
      outstanding <= results_due.size();
    end
  end

  // Stimulus build, reset and end of run
  initial begin
    srw_pkg::req_t             r;
    int                        target;
    int                        pick;
    int                        n;
    int                        j;
    int                        tmp;
    int                        order [12];
    logic [srw_pkg::SEQ_W-1:0] gen_sid;
    logic [srw_pkg::SEQ_W-1:0] gen_base;
    bit                        key;

    // Directed: unlocked and unused codes first
    queue_item(rand_item(srw_pkg::CMD_RECORD));
    queue_item(rand_item(srw_pkg::CMD_POP));
    queue_item(rand_item(srw_pkg::CMD_SKIP));
    for (int c = srw_pkg::CMD_RESET + 1; c <= CMD_LAST; c++) queue_item(rand_item(3'(c)));
    // Lock just below the sequence wrap
    queue_item(header_item(32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0));
    r = record_item(16'd0);
    r.command_data = '1;
    queue_item(r);
    r = record_item(16'd0);
    r.command_data = '0;
    queue_item(r);                              // occupied slot
    queue_item(record_item(16'd5));
    queue_item(record_item(16'd63));            // last slot, wraps past zero
    queue_item(record_item(16'd64));            // one past the window
    queue_item(record_item(16'hFFFF));
    queue_item(rand_item(srw_pkg::CMD_POP));    // delivers head
    queue_item(rand_item(srw_pkg::CMD_POP));    // head empty
    queue_item(rand_item(srw_pkg::CMD_SKIP));   // jumps the gap
    queue_item(rand_item(srw_pkg::CMD_SKIP));   // head ready, no jump
    queue_item(rand_item(srw_pkg::CMD_POP));
    // Same stream, base behind the head: late record
    queue_item(header_item(32'hFFFF_FFFF, 32'hFFFF_FF00, 1'b0));
    queue_item(record_item(16'd0));
    // Keyframe relock, then nothing buffered to skip to
    queue_item(header_item(32'hFFFF_FFFF, 32'h0, 1'b1));
    queue_item(rand_item(srw_pkg::CMD_SKIP));
    // New stream
    queue_item(header_item(32'h0, 32'h0, 1'b0));
    queue_item(record_item(16'd1));
    queue_item(rand_item(srw_pkg::CMD_POP));
    queue_item(rand_item(srw_pkg::CMD_SKIP));
    queue_item(rand_item(srw_pkg::CMD_RESET));
    queue_item(rand_item(srw_pkg::CMD_POP));

    // Random: mostly shuffled packets, some noise and window resets
    target = stim_q.size() + RANDOM_ITEMS;
    gen_sid = $urandom;
    gen_base = $urandom;
    while (stim_q.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        tmp = $urandom_range(99);
        key = 1'b0;
        if (tmp < 10) begin
          gen_sid = $urandom;
          gen_base = ($urandom_range(3) == 0) ? 32'hFFFF_FFC0 + $urandom_range(63)
                                              : $urandom;
        end else begin
          key = tmp < 16;
        end
        queue_item(header_item(gen_sid, gen_base, key));
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) order[i] = i;
        for (int i = n - 1; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < n; i++) begin
          tmp = $urandom_range(99);
          // some records lost (gaps), stray or repeated
          if (tmp >= 8) begin
            if (tmp < 16) r = record_item(16'($urandom_range(80)));
            else if (tmp < 21) r = record_item(16'(order[0]));
            else r = record_item(16'(order[i]));
            queue_item(r);
          end
          if ($urandom_range(99) < 25) queue_item(rand_item(srw_pkg::CMD_POP));
        end
        for (int i = 0; i < n + 2; i++) begin
          queue_item(rand_item(srw_pkg::CMD_POP));
          if ($urandom_range(99) < 20) queue_item(rand_item(srw_pkg::CMD_SKIP));
        end
        gen_base += 32'(n);
      end else if (pick < 92) begin
        queue_item(rand_item(3'($urandom_range(7))));
      end else if (pick < 95) begin
        queue_item(rand_item(srw_pkg::CMD_RESET));
      end else begin
        queue_item(rand_item(srw_pkg::CMD_SKIP));
      end
    end

    // Points where the sender waits for the block to empty
    for (int i = 150; i < stim_q.size(); i += 250) stim_q[i].drain_first = 1'b1;
    total_items = stim_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (!(accepted_total == total_items && outstanding == 0));
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
